// ----- src/crmag_pkg.sv -----
// Shared types and constants for the crop/rotate/mirror address generator.
package crmag_pkg;

    localparam int MAX_DIM = 16384;
    localparam int MAX_BPP = 16;
    localparam int BPP_W   = $clog2(MAX_BPP + 1);

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_CROP   = 2'd1,
        ST_PIXELS = 2'd2,
        ST_IDLE   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MIR_NONE = 2'd0,
        MIR_ROWS = 2'd1,
        MIR_COLS = 2'd2,
        MIR_RSVD = 2'd3
    } t_mirror;

    typedef enum logic [2:0] {
        REG_CROP_LEFT   = 3'd0,
        REG_CROP_TOP    = 3'd1,
        REG_CROP_WIDTH  = 3'd2,
        REG_CROP_HEIGHT = 3'd3,
        REG_TURNS       = 3'd4,
        REG_MIRROR      = 3'd5,
        REG_PITCH       = 3'd6,
        REG_BPP         = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [13:0] crop_left;
        logic [13:0] crop_top;
        logic [14:0] crop_width;
        logic [14:0] crop_height;
        logic [1:0]  quarter_turns;
        logic [1:0]  mirror_mode;
        logic [19:0] source_pitch;
        logic [4:0]  bytes_per_pixel;
        logic [29:0] crop_area;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        t_status          status;
        logic             last;
        logic [14:0]      sy;
        logic [14:0]      sx;
        logic [27:0]      didx;
        logic [19:0]      pitch;
        logic [BPP_W-1:0] bpp;
    } t_work;

endpackage

// ----- src/crmag_cfg.sv -----
// Configuration register file with a running crop area product.
module crmag_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [19:0]         i_cfg_data,
    output crmag_pkg::t_cfg     o_cfg
);
    import crmag_pkg::*;

    t_cfg        r_cfg;
    logic [29:0] area_w;
    logic [29:0] area_h;

    assign area_w = i_cfg_data[14:0] * r_cfg.crop_height;
    assign area_h = r_cfg.crop_width * i_cfg_data[14:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{bytes_per_pixel: 5'd1, default: '0};
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_CROP_LEFT:   r_cfg.crop_left <= i_cfg_data[13:0];
                REG_CROP_TOP:    r_cfg.crop_top <= i_cfg_data[13:0];
                REG_CROP_WIDTH: begin
                    r_cfg.crop_width <= i_cfg_data[14:0];
                    r_cfg.crop_area  <= area_w;
                end
                REG_CROP_HEIGHT: begin
                    r_cfg.crop_height <= i_cfg_data[14:0];
                    r_cfg.crop_area   <= area_h;
                end
                REG_TURNS:       r_cfg.quarter_turns <= i_cfg_data[1:0];
                REG_MIRROR:      r_cfg.mirror_mode <= i_cfg_data[1:0];
                REG_PITCH:       r_cfg.source_pitch <= i_cfg_data[19:0];
                REG_BPP:         r_cfg.bytes_per_pixel <= i_cfg_data[4:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/crmag_walk.sv -----
// Frame control: start checks, raster walk and source coordinate mapping.
module crmag_walk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crmag_pkg::t_cfg     i_cfg,
    input  logic                i_valid,
    input  logic                i_kind,
    input  logic [14:0]         i_image_width,
    input  logic [14:0]         i_image_height,
    input  logic [28:0]         i_max_pixels,
    input  logic                i_take,
    output logic                o_ready,
    output crmag_pkg::t_work    o_work
);
    import crmag_pkg::*;

    logic             r_running;
    logic [13:0]      r_col;
    logic [13:0]      r_row;
    logic [14:0]      r_out_w;
    logic [14:0]      r_out_h;
    logic [27:0]      r_didx;
    logic [13:0]      r_lat_left;
    logic [13:0]      r_lat_top;
    logic [14:0]      r_lat_w;
    logic [14:0]      r_lat_h;
    logic [1:0]       r_lat_turns;
    logic [1:0]       r_lat_mirror;
    logic [19:0]      r_lat_pitch;
    logic [BPP_W-1:0] r_lat_bpp;
    t_work            r_work;
    t_work            n_work;

    logic             acc;
    logic             crop_ok;
    logic             area_ok;
    logic [6:0]       bpp_ext;
    logic [BPP_W-1:0] bpp_clamp;
    logic [13:0]      rx;
    logic [13:0]      ry;
    logic [13:0]      cx;
    logic [13:0]      cy;
    logic             col_end;
    logic             row_end;
    logic             last;

    assign o_ready = !r_work.valid || i_take;
    assign acc     = i_valid && o_ready;

    always_comb begin
        crop_ok = (i_cfg.crop_width != '0) && (i_cfg.crop_height != '0)
               && ({2'b0, i_cfg.crop_width} <= 17'(MAX_DIM))
               && ({2'b0, i_cfg.crop_height} <= 17'(MAX_DIM))
               && ({2'b0, i_cfg.crop_left} + {1'b0, i_cfg.crop_width}
                   <= {1'b0, i_image_width})
               && ({2'b0, i_cfg.crop_top} + {1'b0, i_cfg.crop_height}
                   <= {1'b0, i_image_height});
        area_ok = i_cfg.crop_area <= {1'b0, i_max_pixels};
        bpp_ext = 7'(i_cfg.bytes_per_pixel);
        if (bpp_ext == '0) begin
            bpp_clamp = BPP_W'(1);
        end else if (bpp_ext > 7'(MAX_BPP)) begin
            bpp_clamp = BPP_W'(MAX_BPP);
        end else begin
            bpp_clamp = BPP_W'(bpp_ext);
        end
    end

    always_comb begin
        rx = (t_mirror'(r_lat_mirror) == MIR_COLS)
           ? 14'(r_out_w - 15'd1 - {1'b0, r_col}) : r_col;
        ry = (t_mirror'(r_lat_mirror) == MIR_ROWS)
           ? 14'(r_out_h - 15'd1 - {1'b0, r_row}) : r_row;
        unique case (r_lat_turns)
            2'd0: begin
                cx = rx;
                cy = ry;
            end
            2'd1: begin
                cx = 14'(r_lat_w - 15'd1 - {1'b0, ry});
                cy = rx;
            end
            2'd2: begin
                cx = 14'(r_lat_w - 15'd1 - {1'b0, rx});
                cy = 14'(r_lat_h - 15'd1 - {1'b0, ry});
            end
            default: begin
                cx = ry;
                cy = 14'(r_lat_h - 15'd1 - {1'b0, rx});
            end
        endcase
        col_end = ({1'b0, r_col} + 15'd1) >= r_out_w;
        row_end = ({1'b0, r_row} + 15'd1) >= r_out_h;
        last    = col_end && row_end;
    end

    always_comb begin
        n_work       = '0;
        n_work.valid = 1'b1;
        if (i_kind == KIND_START) begin
            if (!crop_ok) begin
                n_work.status = ST_CROP;
            end else if (!area_ok) begin
                n_work.status = ST_PIXELS;
            end else begin
                n_work.status = ST_OK;
            end
        end else if (!r_running) begin
            n_work.status = ST_IDLE;
        end else begin
            n_work.status = ST_OK;
            n_work.last   = last;
            n_work.sy     = {1'b0, r_lat_top} + {1'b0, cy};
            n_work.sx     = {1'b0, r_lat_left} + {1'b0, cx};
            n_work.didx   = r_didx;
            n_work.pitch  = r_lat_pitch;
            n_work.bpp    = r_lat_bpp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running    <= 1'b0;
            r_col        <= '0;
            r_row        <= '0;
            r_out_w      <= '0;
            r_out_h      <= '0;
            r_didx       <= '0;
            r_lat_left   <= '0;
            r_lat_top    <= '0;
            r_lat_w      <= '0;
            r_lat_h      <= '0;
            r_lat_turns  <= '0;
            r_lat_mirror <= '0;
            r_lat_pitch  <= '0;
            r_lat_bpp    <= BPP_W'(1);
            r_work       <= '0;
        end else begin
            if (acc) begin
                r_work <= n_work;
            end else if (i_take) begin
                r_work.valid <= 1'b0;
            end
            if (acc && i_kind == KIND_START) begin
                r_running <= crop_ok && area_ok;
                if (crop_ok && area_ok) begin
                    r_lat_left   <= i_cfg.crop_left;
                    r_lat_top    <= i_cfg.crop_top;
                    r_lat_w      <= i_cfg.crop_width;
                    r_lat_h      <= i_cfg.crop_height;
                    r_lat_turns  <= i_cfg.quarter_turns;
                    r_lat_mirror <= i_cfg.mirror_mode;
                    r_lat_pitch  <= i_cfg.source_pitch;
                    r_lat_bpp    <= bpp_clamp;
                    r_out_w      <= i_cfg.quarter_turns[0] ? i_cfg.crop_height
                                                           : i_cfg.crop_width;
                    r_out_h      <= i_cfg.quarter_turns[0] ? i_cfg.crop_width
                                                           : i_cfg.crop_height;
                    r_col        <= '0;
                    r_row        <= '0;
                    r_didx       <= '0;
                end
            end else if (acc && r_running) begin
                if (last) begin
                    r_running <= 1'b0;
                end else begin
                    r_didx <= r_didx + 28'd1;
                    if (col_end) begin
                        r_col <= '0;
                        r_row <= r_row + 14'd1;
                    end else begin
                        r_col <= r_col + 14'd1;
                    end
                end
            end
        end
    end

    assign o_work = r_work;

    a_walk_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> ({1'b0, r_col} < r_out_w) && ({1'b0, r_row} < r_out_h))
        else $error("walk position outside output frame");

    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_kind == KIND_STEP && r_running && last |=> !r_running)
        else $error("frame still running after last pixel");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_work.valid && r_work.status != ST_OK
        |-> r_work.sx == '0 && r_work.sy == '0 && r_work.didx == '0 && !r_work.last)
        else $error("error word carries coordinates");

endmodule

// ----- src/crmag_addr.sv -----
// Offset multipliers and output register.
module crmag_addr (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crmag_pkg::t_work    i_work,
    input  logic                i_m_tready,
    output logic                o_take,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic [35:0]         o_source_offset,
    output logic [31:0]         o_dest_offset,
    output logic                o_last
);
    import crmag_pkg::*;

    logic                r_out_valid;
    logic [1:0]          r_status;
    logic [35:0]         r_src;
    logic [31:0]         r_dst;
    logic                r_last;
    logic [34:0]         p_row;
    logic [14+BPP_W:0]   p_col;
    logic [27+BPP_W:0]   p_dst;

    assign o_take = i_work.valid && (!r_out_valid || i_m_tready);

    assign p_row = i_work.sy * i_work.pitch;
    assign p_col = i_work.sx * i_work.bpp;
    assign p_dst = i_work.didx * i_work.bpp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_status <= i_work.status;
            r_src    <= 36'(p_row) + 36'(p_col);
            r_dst    <= 32'(p_dst);
            r_last   <= i_work.last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_source_offset = r_src;
    assign o_dest_offset   = r_dst;
    assign o_last          = r_last;

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> r_out_valid)
        else $error("taken word did not reach output");

    a_err_offsets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != ST_OK |-> r_src == '0 && r_dst == '0 && !r_last)
        else $error("error word with nonzero offsets");

endmodule

// ----- src/crop_rotate_mirror_address_gen.sv -----
// Top level of the crop/rotate/mirror address generator.
// A word accepted on the slave side passes the walk work register and then the output register to the master side.
// Throughput: one word per cycle, start and step words alike, under no backpressure.
// The rate is set by the coordinate stage and the multiplier stage.
// Reset (synchronous, active low) idles the walk and loads register defaults.
module crop_rotate_mirror_address_gen (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [19:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // image_width, image_height, max_pixels
    input  logic [0:0]   s_axis_tuser,   // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,   // source_offset, dest_offset
    output logic [1:0]   m_axis_tuser,   // status
    output logic         m_axis_tlast
);
    import crmag_pkg::*;

    t_cfg        cfg;
    t_work       work;
    logic        take;
    logic [35:0] src;
    logic [31:0] dst;

    crmag_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    crmag_walk u_walk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_valid        (s_axis_tvalid),
        .i_kind         (s_axis_tuser[0]),
        .i_image_width  (s_axis_tdata[14:0]),
        .i_image_height (s_axis_tdata[29:15]),
        .i_max_pixels   (s_axis_tdata[58:30]),
        .i_take         (take),
        .o_ready        (s_axis_tready),
        .o_work         (work)
    );

    crmag_addr u_addr (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_work          (work),
        .i_m_tready      (m_axis_tready),
        .o_take          (take),
        .o_valid         (m_axis_tvalid),
        .o_status        (m_axis_tuser),
        .o_source_offset (src),
        .o_dest_offset   (dst),
        .o_last          (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, dst, src};

endmodule

// ----- tb/sv/crop_rotate_mirror_address_gen_test.sv -----
// Self-checking stream testbench for the crop/rotate/mirror address generator.
module crop_rotate_mirror_address_gen_test;
    timeunit 1ns;
    timeprecision 1ps;

    import crmag_pkg::*;

    localparam int          RANDOM_WORDS = 1300;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [28:0] MP_MAX       = 29'h1FFFFFFF;

    typedef struct {
        t_status     status;
        logic [35:0] src;
        logic [31:0] dst;
        logic        last;
    } t_addr_word;

    typedef struct {
        bit          is_cfg;
        t_cfg_idx    idx;
        logic [19:0] value;
        logic        kind;
        logic [14:0] iw;
        logic [14:0] ih;
        logic [28:0] mp;
        bit          known;
        t_addr_word  exp;
    } t_row;

    logic         i_clk;
    logic         i_rst_n       = 1'b0;
    logic         i_cfg_we      = 1'b0;
    logic [2:0]   i_cfg_idx     = '0;
    logic [19:0]  i_cfg_data    = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata  = '0;   // image_width, image_height, max_pixels
    logic [0:0]   s_axis_tuser  = '0;   // kind
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;         // source_offset, dest_offset
    logic [1:0]   m_axis_tuser;         // status
    logic         m_axis_tlast;

    crop_rotate_mirror_address_gen DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // register shadow
    logic [13:0] cfg_left   = '0;
    logic [13:0] cfg_top    = '0;
    logic [14:0] cfg_width  = '0;
    logic [14:0] cfg_height = '0;
    logic [1:0]  cfg_turns  = '0;
    logic [1:0]  cfg_mirror = '0;
    logic [19:0] cfg_pitch  = '0;
    logic [4:0]  cfg_bpp    = 5'd1;

    // walk state, latched at a good start
    bit          walk_on   = 1'b0;
    logic [13:0] walk_col  = '0;
    logic [13:0] walk_row  = '0;
    logic [14:0] walk_w    = '0;
    logic [14:0] walk_h    = '0;
    logic [27:0] walk_didx = '0;
    logic [13:0] lat_left  = '0;
    logic [13:0] lat_top   = '0;
    logic [14:0] lat_w     = '0;
    logic [14:0] lat_h     = '0;
    logic [1:0]  lat_turns = '0;
    t_mirror     lat_mirror = MIR_NONE;
    logic [19:0] lat_pitch = '0;
    logic [4:0]  lat_bpp   = 5'd1;

    t_addr_word pending_addrs[$];
    t_row       directed_rows[$];

    int  errors        = 0;
    int  words_sent    = 0;
    int  words_checked = 0;
    int  cycle_count   = 0;
    bit  steady        = 1'b0;
    int  frames_opened = 0;
    int  crops_refused = 0;
    int  limits_hit    = 0;
    int  idle_steps    = 0;
    int  pixels_out    = 0;
    int  frames_done   = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                 pending_addrs.size());
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_addr_word predict_addr_word(logic kind, logic [14:0] iw,
                                                     logic [14:0] ih, logic [28:0] mp);
        t_addr_word       r;
        longint unsigned  w, h, x, y, rx, ry, cx, cy, src, dst;
        bit               fin;
        r.status = ST_OK;
        r.src    = '0;
        r.dst    = '0;
        r.last   = 1'b0;
        if (kind == KIND_START) begin
            walk_on = 1'b0;
            w = cfg_width;
            h = cfg_height;
            if (w == 0 || h == 0 || w > MAX_DIM || h > MAX_DIM ||
                    cfg_left + w > iw || cfg_top + h > ih) begin
                r.status = ST_CROP;
                crops_refused++;
            end else if (w * h > mp) begin
                r.status = ST_PIXELS;
                limits_hit++;
            end else begin
                lat_left   = cfg_left;
                lat_top    = cfg_top;
                lat_w      = cfg_width;
                lat_h      = cfg_height;
                lat_turns  = cfg_turns;
                lat_mirror = t_mirror'(cfg_mirror);
                lat_pitch  = cfg_pitch;
                lat_bpp    = (cfg_bpp == 0) ? 5'd1 : (cfg_bpp > MAX_BPP) ? 5'(MAX_BPP) : cfg_bpp;
                walk_w     = lat_turns[0] ? lat_h : lat_w;
                walk_h     = lat_turns[0] ? lat_w : lat_h;
                walk_col   = '0;
                walk_row   = '0;
                walk_didx  = '0;
                walk_on    = 1'b1;
                frames_opened++;
            end
        end else if (!walk_on) begin
            r.status = ST_IDLE;
            idle_steps++;
        end else begin
            x  = walk_col;
            y  = walk_row;
            rx = (lat_mirror == MIR_COLS) ? walk_w - 1 - x : x;
            ry = (lat_mirror == MIR_ROWS) ? walk_h - 1 - y : y;
            case (lat_turns)
                2'd0: begin cx = rx;             cy = ry;             end
                2'd1: begin cx = lat_w - 1 - ry; cy = rx;             end
                2'd2: begin cx = lat_w - 1 - rx; cy = lat_h - 1 - ry; end
                default: begin cx = ry;          cy = lat_h - 1 - rx; end
            endcase
            src = (lat_top + cy) * lat_pitch + (lat_left + cx) * lat_bpp;
            dst = longint'(walk_didx) * lat_bpp;
            fin = (x + 1 >= walk_w) && (y + 1 >= walk_h);
            r.src  = src[35:0];
            r.dst  = dst[31:0];
            r.last = fin;
            pixels_out++;
            if (fin) begin
                walk_on = 1'b0;
                frames_done++;
            end else begin
                walk_didx = walk_didx + 1'b1;
                if (x + 1 >= walk_w) begin
                    walk_col = '0;
                    walk_row = 14'(y + 1);
                end else begin
                    walk_col = 14'(x + 1);
                end
            end
        end
        return r;
    endfunction

    function automatic t_row word_row(logic kind, logic [14:0] iw, logic [14:0] ih,
                                      logic [28:0] mp);
        t_row r;
        r.is_cfg = 1'b0;
        r.idx    = REG_CROP_LEFT;
        r.value  = '0;
        r.kind   = kind;
        r.iw     = iw;
        r.ih     = ih;
        r.mp     = mp;
        r.known  = 1'b0;
        r.exp.status = ST_OK;
        r.exp.src    = '0;
        r.exp.dst    = '0;
        r.exp.last   = 1'b0;
        return r;
    endfunction

    function automatic t_row known_row(logic kind, logic [14:0] iw, logic [14:0] ih,
                                       logic [28:0] mp, t_status st, logic [35:0] src,
                                       logic [31:0] dst, logic last);
        t_row r;
        r = word_row(kind, iw, ih, mp);
        r.known      = 1'b1;
        r.exp.status = st;
        r.exp.src    = src;
        r.exp.dst    = dst;
        r.exp.last   = last;
        return r;
    endfunction

    function automatic t_row reg_row(t_cfg_idx idx, logic [19:0] value);
        t_row r;
        r = word_row(KIND_STEP, '0, '0, '0);
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.value  = value;
        return r;
    endfunction

    function automatic logic [19:0] rand_reg_value(t_cfg_idx idx);
        logic [19:0] v;
        int          p;
        v = 20'($urandom);
        p = $urandom_range(0, 99);
        case (idx)
            REG_CROP_LEFT, REG_CROP_TOP: begin
                if (p < 10)      v[13:0] = 14'h3FFF;
                else if (p >= 20) v[13:0] = 14'($urandom_range(0, 40));
            end
            REG_CROP_WIDTH, REG_CROP_HEIGHT: begin
                if (p < 4)       v[14:0] = 15'(MAX_DIM);
                else if (p < 7)  v[14:0] = v[14:0];
                else if (p < 10) v[14:0] = '0;
                else             v[14:0] = 15'($urandom_range(1, 6));
            end
            REG_PITCH: begin
                if (p < 10)      v = '0;
                else if (p < 20) v = 20'hFFFFF;
            end
            REG_BPP: begin
                if (p >= 15) v[4:0] = 5'($urandom_range(1, MAX_BPP));
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic cfg_write(t_cfg_idx idx, logic [19:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            REG_CROP_LEFT:   cfg_left   = value[13:0];
            REG_CROP_TOP:    cfg_top    = value[13:0];
            REG_CROP_WIDTH:  cfg_width  = value[14:0];
            REG_CROP_HEIGHT: cfg_height = value[14:0];
            REG_TURNS:       cfg_turns  = value[1:0];
            REG_MIRROR:      cfg_mirror = value[1:0];
            REG_PITCH:       cfg_pitch  = value;
            REG_BPP:         cfg_bpp    = value[4:0];
            default: ;
        endcase
    endtask

    task automatic send_word(logic kind, logic [14:0] iw, logic [14:0] ih, logic [28:0] mp,
                             bit use_given, t_addr_word given);
        t_addr_word exp;
        while (!steady && $urandom_range(0, 99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, mp, ih, iw};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        exp = predict_addr_word(kind, iw, ih, mp);
        pending_addrs.push_back(use_given ? given : exp);
        words_sent++;
    endtask

    // sender holds off until the master side has caught up
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_addrs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
        errors++;
        if (errors <= 40)
            $display("mismatch at word %0d: %s got %0h want %0h", words_checked, what, got,
                     want);
    endtask

    task automatic check_word();
        t_addr_word got, exp;
        got.status = t_status'(m_axis_tuser);
        got.src    = m_axis_tdata[35:0];
        got.dst    = m_axis_tdata[67:36];
        got.last   = m_axis_tlast;
        if (pending_addrs.size() == 0) begin
            flag_mismatch("word with nothing pending, status", got.status, 0);
        end else begin
            exp = pending_addrs.pop_front();
            if (got.status != exp.status) flag_mismatch("status", got.status, exp.status);
            if (got.src != exp.src)       flag_mismatch("source_offset", got.src, exp.src);
            if (got.dst != exp.dst)       flag_mismatch("dest_offset", got.dst, exp.dst);
            if (got.last != exp.last)     flag_mismatch("last", got.last, exp.last);
        end
        words_checked++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_word();
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 10);
    end

    initial begin
        int              p, n_frames, steps, mid, k;
        longint unsigned area, ext_w, ext_h, mpv;
        logic [14:0]     iw, ih;
        logic [28:0]     mp;
        bit              cfg_open;
        t_cfg_idx        idx_pick;
        t_addr_word      blank;

        blank.status = ST_OK;
        blank.src    = '0;
        blank.dst    = '0;
        blank.last   = 1'b0;

        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_rows.push_back(known_row(KIND_STEP, 0, 0, 0, ST_IDLE, 0, 0, 0));
        directed_rows.push_back(known_row(KIND_START, 100, 100, 1000, ST_CROP, 0, 0, 0));
        directed_rows.push_back(reg_row(REG_CROP_LEFT, 1));
        directed_rows.push_back(reg_row(REG_CROP_TOP, 2));
        directed_rows.push_back(reg_row(REG_CROP_WIDTH, 2));
        directed_rows.push_back(reg_row(REG_CROP_HEIGHT, 3));
        directed_rows.push_back(reg_row(REG_PITCH, 100));
        directed_rows.push_back(reg_row(REG_BPP, 4));
        directed_rows.push_back(known_row(KIND_START, 3, 5, 6, ST_OK, 0, 0, 0));
        directed_rows.push_back(known_row(KIND_STEP, 0, 0, 0, ST_OK, 204, 0, 0));
        repeat (5) directed_rows.push_back(word_row(KIND_STEP, 0, 0, 0));
        directed_rows.push_back(known_row(KIND_STEP, 0, 0, 0, ST_IDLE, 0, 0, 0));
        directed_rows.push_back(known_row(KIND_START, 2, 5, 6, ST_CROP, 0, 0, 0));
        directed_rows.push_back(known_row(KIND_START, 3, 4, 6, ST_CROP, 0, 0, 0));
        directed_rows.push_back(known_row(KIND_START, 3, 5, 5, ST_PIXELS, 0, 0, 0));
        // odd turn, column mirror, pixel size zero
        directed_rows.push_back(reg_row(REG_TURNS, 1));
        directed_rows.push_back(reg_row(REG_MIRROR, MIR_COLS));
        directed_rows.push_back(reg_row(REG_BPP, 0));
        directed_rows.push_back(reg_row(REG_CROP_HEIGHT, 1));
        directed_rows.push_back(known_row(KIND_START, 3, 5, MP_MAX, ST_OK, 0, 0, 0));
        repeat (2) directed_rows.push_back(word_row(KIND_STEP, 0, 0, 0));
        // far corner, widest pitch, oversize pixel
        directed_rows.push_back(reg_row(REG_TURNS, 3));
        directed_rows.push_back(reg_row(REG_MIRROR, MIR_ROWS));
        directed_rows.push_back(reg_row(REG_BPP, 31));
        directed_rows.push_back(reg_row(REG_CROP_LEFT, 16383));
        directed_rows.push_back(reg_row(REG_CROP_TOP, 16383));
        directed_rows.push_back(reg_row(REG_CROP_WIDTH, 1));
        directed_rows.push_back(reg_row(REG_PITCH, 20'hFFFFF));
        directed_rows.push_back(known_row(KIND_START, 16384, 16384, 1, ST_OK, 0, 0, 0));
        directed_rows.push_back(word_row(KIND_STEP, 0, 0, 0));
        // full size frame, reserved mirror, abandoned by later starts
        directed_rows.push_back(reg_row(REG_CROP_LEFT, 0));
        directed_rows.push_back(reg_row(REG_CROP_TOP, 0));
        directed_rows.push_back(reg_row(REG_CROP_WIDTH, 16384));
        directed_rows.push_back(reg_row(REG_CROP_HEIGHT, 16384));
        directed_rows.push_back(reg_row(REG_TURNS, 2));
        directed_rows.push_back(reg_row(REG_MIRROR, MIR_RSVD));
        directed_rows.push_back(known_row(KIND_START, 16384, 16384, 29'h10000000, ST_OK,
                                          0, 0, 0));
        repeat (2) directed_rows.push_back(word_row(KIND_STEP, 0, 0, 0));
        directed_rows.push_back(reg_row(REG_CROP_WIDTH, 16385));
        directed_rows.push_back(known_row(KIND_START, 15'h7FFF, 15'h7FFF, MP_MAX, ST_CROP,
                                          0, 0, 0));
        directed_rows.push_back(reg_row(REG_CROP_WIDTH, 16384));
        directed_rows.push_back(known_row(KIND_START, 16384, 16384, 29'h0FFFFFFF, ST_PIXELS,
                                          0, 0, 0));
        directed_rows.push_back(known_row(KIND_STEP, 0, 0, 0, ST_IDLE, 0, 0, 0));

        cfg_open = 1'b0;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                if (!cfg_open) drain_results();
                cfg_write(directed_rows[i].idx, directed_rows[i].value);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    i_cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_word(directed_rows[i].kind, directed_rows[i].iw, directed_rows[i].ih,
                          directed_rows[i].mp, directed_rows[i].known, directed_rows[i].exp);
            end
        end

        while (words_sent < RANDOM_WORDS) begin
            drain_results();
            for (k = 0; k < 8; k++) cfg_write(t_cfg_idx'(k), rand_reg_value(t_cfg_idx'(k)));
            i_cfg_we <= 1'b0;
            n_frames = $urandom_range(1, 3);
            repeat (n_frames) begin
                steady = (words_sent >= 500) && (words_sent < 800);
                p = $urandom_range(0, 99);
                if (p < 8) begin
                    repeat ($urandom_range(1, 3)) begin
                        send_word($urandom_range(0, 1) ? KIND_START : KIND_STEP,
                                  15'($urandom), 15'($urandom), 29'($urandom), 1'b0, blank);
                    end
                end else begin
                    ext_w = cfg_left + cfg_width;
                    ext_h = cfg_top + cfg_height;
                    if (p < 12 && ext_w > 0) ext_w = ext_w - 1;
                    else ext_w = ext_w + $urandom_range(0, 3);
                    if (p >= 12 && p < 15 && ext_h > 0) ext_h = ext_h - 1;
                    else ext_h = ext_h + $urandom_range(0, 3);
                    iw = (ext_w > 32767) ? 15'h7FFF : ext_w[14:0];
                    ih = (ext_h > 32767) ? 15'h7FFF : ext_h[14:0];
                    area = longint'(cfg_width) * cfg_height;
                    p = $urandom_range(0, 99);
                    if (p < 8 && area > 0) mpv = area - 1;
                    else if (p < 16) mpv = $urandom_range(0, MP_MAX);
                    else mpv = area + $urandom_range(0, 3);
                    mp = (mpv > MP_MAX) ? MP_MAX : mpv[28:0];
                    send_word(KIND_START, iw, ih, mp, 1'b0, blank);
                    if (area <= 64)
                        steps = int'(area)
                              + (($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
                    else
                        steps = $urandom_range(1, 6);
                    mid = ($urandom_range(0, 7) == 0) ? $urandom_range(0, steps) : -1;
                    for (k = 0; k < steps; k++) begin
                        if (k == mid) begin
                            // register change inside a frame must wait for the next start
                            drain_results();
                            idx_pick = t_cfg_idx'($urandom_range(0, 7));
                            cfg_write(idx_pick, rand_reg_value(idx_pick));
                            i_cfg_we <= 1'b0;
                        end
                        send_word(KIND_STEP, 15'($urandom), 15'($urandom), 29'($urandom),
                                  1'b0, blank);
                    end
                end
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (10) @(posedge i_clk);
        $display("%0d words checked: %0d frames opened, %0d crops refused, %0d over limit",
                 words_checked, frames_opened, crops_refused, limits_hit);
        $display("%0d pixels addressed, %0d frames walked to the end, %0d idle steps",
                 pixels_out, frames_done, idle_steps);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/crmag_pkg.sv
src/crmag_cfg.sv
src/crmag_walk.sv
src/crmag_addr.sv
src/crop_rotate_mirror_address_gen.sv
tb/sv/crop_rotate_mirror_address_gen_test.sv
